>>> rtl/ptz_absolute_position_framer_defines.svh
// Assertion macros for the absolute position framer.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef PTZ_ABSOLUTE_POSITION_FRAMER_DEFINES_SVH
`define PTZ_ABSOLUTE_POSITION_FRAMER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PTZAPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PTZAPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ptzapf_pkg.sv
// Shared types and constants of the absolute position framer.
// No dependencies; used by the channel interfaces and the top level.
package ptzapf_pkg;

  typedef enum logic [1:0] {
    OP_SET_POS = 2'd0,
    OP_TICK    = 2'd1,
    OP_SET_IVL = 2'd2
  } opcode_e;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_CMD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_CMD = 2'd3;

  localparam logic [7:0] SYNC_RST     = 8'd255;
  localparam logic [7:0] ADDR_RST     = 8'd1;
  localparam logic [7:0] PAN_CMD_RST  = 8'd75;
  localparam logic [7:0] TILT_CMD_RST = 8'd77;

  localparam logic [15:0] HALF_SCALE  = 16'h8000;
  localparam logic [9:0]  ELAPSED_MAX = 10'd1023;
  localparam logic [8:0]  IVL_RST     = 9'd300;
  localparam logic [9:0]  IVL_BASE    = 10'd180;
  localparam logic [9:0]  IVL_WRAP    = 10'd360;

  // Frame byte positions
  localparam logic [2:0] BYTE_SYNC = 3'd0;
  localparam logic [2:0] BYTE_ADDR = 3'd1;
  localparam logic [2:0] BYTE_ZERO = 3'd2;
  localparam logic [2:0] BYTE_CMD  = 3'd3;
  localparam logic [2:0] BYTE_HI   = 3'd4;
  localparam logic [2:0] BYTE_LO   = 3'd5;
  localparam logic [2:0] BYTE_CHK  = 3'd6;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] pan_coarse;
    logic [7:0] pan_fine;
    logic [7:0] tilt_coarse;
    logic [7:0] tilt_fine;
    logic [7:0] new_interval;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } out_item_t;

endpackage

>>> rtl/ptzapf_if.sv
// Valid/ready channel interfaces for the framer's input and output items.
// Depends on ptzapf_pkg for the payload structs.
interface ptzapf_in_if import ptzapf_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface ptzapf_out_if import ptzapf_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

>>> rtl/ptz_absolute_position_framer.sv
// Absolute pan/tilt position command framer; depends on ptzapf_pkg, ptzapf_if
// and ptz_absolute_position_framer_defines.svh.
//
// in_i carries set-position, millisecond-tick and set-interval items; out_o
// carries frame bytes, one per beat, frame_end high on the seventh (checksum)
// byte. cfg_we_i/cfg_idx_i/cfg_data_i write the sync, address and command
// registers; write them only while the block is idle.
// An accepted item lands in an input register and is worked off from there,
// so the block takes one item per cycle unless a sending tick waits there for
// the frame buffer. A tick that sends loads the seven-byte frame buffer; its
// bytes pass through the output register to out_o, one per cycle while out_o
// is ready. A sending tick that finds the frame buffer still in use waits in
// the input register until the buffer's last byte has gone to the output
// register. Items that send nothing pass while a frame drains.
// A stall on out_o holds the output byte and, once the buffer is busy and a
// further send waits, backs up to in_i.ready.
// Reset loads the register defaults, clears targets, sent positions and the
// elapsed count, sets the interval to 300 ms and empties all stages.
`include "ptz_absolute_position_framer_defines.svh"

module ptz_absolute_position_framer import ptzapf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ptzapf_in_if.sink            in_i,
  ptzapf_out_if.source         out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i
);

  // Configuration
  logic [7:0] sync_q, addr_q, pan_cmd_q, tilt_cmd_q;

  // Input register
  logic       stg_valid_q;
  in_item_t   stg_q;
  logic       stg_go, in_ready;

  // Block state
  logic [15:0] tgt_pan_q, tgt_tilt_q, sent_pan_q, sent_tilt_q;
  logic [9:0]  elapsed_q;
  logic [8:0]  interval_q;

  // Frame buffer and serialiser
  logic        frm_busy_q;
  logic [2:0]  frm_idx_q;
  logic [7:0]  frm_cmd_q;
  logic [15:0] frm_val_q;
  logic        frm_load, ser_load, ser_last;
  logic [7:0]  ser_byte, chk;

  // Output register
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_end_q;

  // Work on the staged item
  logic [15:0] pan_in, tilt_in, pan_new, tilt_new;
  logic        fold, is_tick, due, pick_pan, pick_tilt, send;
  logic [9:0]  elapsed_inc;
  logic [16:0] pan_diff, tilt_diff, pan_mag, tilt_mag;
  logic [15:0] pan_chg, tilt_chg, sel_chg, sel_pos;
  logic [7:0]  sel_cmd;
  logic [21:0] ivl_sum;
  logic [9:0]  ivl_raw, ivl_adj;
  logic [26:0] val_sum;

  always_comb begin
    pan_in   = {stg_q.pan_coarse, stg_q.pan_fine};
    tilt_in  = {stg_q.tilt_coarse, stg_q.tilt_fine};
    // fold a tilt past the quarter turn back over the top
    fold     = (tilt_in[15:14] != 2'b00);
    pan_new  = fold ? (pan_in ^ HALF_SCALE) : pan_in;
    tilt_new = fold ? (HALF_SCALE - tilt_in) : tilt_in;

    is_tick     = (stg_q.opcode == OP_TICK);
    elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 10'd1;
    due         = (elapsed_inc >= {1'b0, interval_q});

    pan_diff  = {sent_pan_q[15], sent_pan_q} - {tgt_pan_q[15], tgt_pan_q};
    tilt_diff = {sent_tilt_q[15], sent_tilt_q} - {tgt_tilt_q[15], tgt_tilt_q};
    pan_mag   = pan_diff[16] ? (17'd0 - pan_diff) : pan_diff;
    tilt_mag  = tilt_diff[16] ? (17'd0 - tilt_diff) : tilt_diff;
    pan_chg   = pan_mag[15:0];
    tilt_chg  = tilt_mag[15:0];

    pick_pan  = (pan_chg != 16'd0) && (pan_chg >= tilt_chg);
    pick_tilt = !pick_pan && (tilt_chg != 16'd0);
    send      = stg_valid_q && is_tick && due && (pick_pan || pick_tilt);

    sel_chg = pick_pan ? pan_chg : tilt_chg;
    sel_pos = pick_pan ? tgt_pan_q : tgt_tilt_q;
    sel_cmd = pick_pan ? pan_cmd_q : tilt_cmd_q;

    // round(change * 360 / 65536) + 180, less 180 again if that reaches 360
    ivl_sum = 22'(sel_chg) * 22'd45 + 22'd4096;
    ivl_raw = {1'b0, ivl_sum[21:13]} + IVL_BASE;
    ivl_adj = (ivl_raw >= IVL_WRAP) ? (ivl_raw - IVL_BASE) : ivl_raw;

    // round(pos * 36000 / 65536)
    val_sum = 27'(sel_pos) * 27'd1125 + 27'd1024;
  end

  // a sending tick waits while the frame buffer drains
  assign stg_go   = stg_valid_q && (!frm_busy_q || !send);
  assign in_ready = !stg_valid_q || stg_go;
  assign frm_load = stg_go && send;

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q     <= SYNC_RST;
      addr_q     <= ADDR_RST;
      pan_cmd_q  <= PAN_CMD_RST;
      tilt_cmd_q <= TILT_CMD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SYNC:     sync_q     <= cfg_data_i;
        REG_ADDR:     addr_q     <= cfg_data_i;
        REG_PAN_CMD:  pan_cmd_q  <= cfg_data_i;
        REG_TILT_CMD: tilt_cmd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready) begin
      stg_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      stg_q <= in_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_pan_q   <= '0;
      tgt_tilt_q  <= '0;
      sent_pan_q  <= '0;
      sent_tilt_q <= '0;
      elapsed_q   <= '0;
      interval_q  <= IVL_RST;
    end else if (stg_go) begin
      case (stg_q.opcode)
        OP_SET_POS: begin
          tgt_pan_q  <= pan_new;
          tgt_tilt_q <= tilt_new;
        end
        OP_SET_IVL: begin
          interval_q <= {1'b0, stg_q.new_interval};
        end
        OP_TICK: begin
          if (send) begin
            if (pick_pan) begin
              sent_pan_q <= tgt_pan_q;
            end else begin
              sent_tilt_q <= tgt_tilt_q;
            end
            elapsed_q  <= '0;
            interval_q <= ivl_adj[8:0];
          end else begin
            elapsed_q <= elapsed_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // Serialiser: advance one byte whenever the output register frees up
  assign ser_load = frm_busy_q && (!out_valid_q || out_o.ready);
  assign ser_last = (frm_idx_q == BYTE_CHK);
  assign chk      = addr_q + frm_cmd_q + frm_val_q[15:8] + frm_val_q[7:0];

  always_comb begin
    case (frm_idx_q)
      BYTE_SYNC: ser_byte = sync_q;
      BYTE_ADDR: ser_byte = addr_q;
      BYTE_ZERO: ser_byte = 8'h00;
      BYTE_CMD:  ser_byte = frm_cmd_q;
      BYTE_HI:   ser_byte = frm_val_q[15:8];
      BYTE_LO:   ser_byte = frm_val_q[7:0];
      BYTE_CHK:  ser_byte = chk;
      default:   ser_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frm_busy_q <= 1'b0;
      frm_idx_q  <= BYTE_SYNC;
    end else if (frm_load) begin
      frm_busy_q <= 1'b1;
      frm_idx_q  <= BYTE_SYNC;
    end else if (ser_load) begin
      frm_busy_q <= !ser_last;
      frm_idx_q  <= ser_last ? BYTE_SYNC : frm_idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frm_load) begin
      frm_cmd_q <= sel_cmd;
      frm_val_q <= val_sum[26:11];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ser_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      out_byte_q <= ser_byte;
      out_end_q  <= ser_last;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.item.frame_byte = out_byte_q;
  assign out_o.item.frame_end  = out_end_q;

  `PTZAPF_ASSERT_NOW(a_load_when_free, frm_load, !frm_busy_q, "frame buffer overwritten while busy")
  `PTZAPF_ASSERT_NOW(a_idx_only_busy, frm_idx_q != BYTE_SYNC, frm_busy_q, "byte index set while idle")
  `PTZAPF_ASSERT_NEXT(a_send_clears, frm_load, elapsed_q == 10'd0, "elapsed count not cleared on send")
  `PTZAPF_ASSERT_NEXT(a_end_closes, ser_load && ser_last, !frm_busy_q, "frame buffer busy after last byte")

endmodule
